>>> rtl/tcp_header_payload_checksum_unit_assert.svh
// ----------------------------------------------------------------------------
// tcp header/payload checksum unit - assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef TCP_HEADER_PAYLOAD_CHECKSUM_UNIT_ASSERT_SVH
`define TCP_HEADER_PAYLOAD_CHECKSUM_UNIT_ASSERT_SVH

// same-cycle implication
`define TCPHC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcphc: same-cycle check failed");

// next-cycle implication
`define TCPHC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcphc: next-cycle check failed");

`endif

>>> rtl/tcphc_pkg.sv
// ----------------------------------------------------------------------------
// tcphc_pkg
// shared types and constants of the tcp header/payload checksum unit
// ----------------------------------------------------------------------------
package tcphc_pkg;

    localparam int WORD_W = 16;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // request codes on req_type; the fourth code is ignored
    localparam logic [1:0] REQ_HEADER  = 2'd0;
    localparam logic [1:0] REQ_PAYLOAD = 2'd1;
    localparam logic [1:0] REQ_FINISH  = 2'd2;

    // operation carried to the back part
    typedef enum logic [1:0] {
        OP_HEADER,
        OP_PAYLOAD,
        OP_FINISH
    } op_t;

    // one queued item: header word, payload byte or stored checksum
    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] word;
    } entry_t;

    // queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> rtl/tcphc_front.sv
// ----------------------------------------------------------------------------
// tcphc_front
// classifies accepted items and folds a header into one 16-bit word
// ----------------------------------------------------------------------------
module tcphc_front
    import tcphc_pkg::*;
(
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  req_type,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [31:0] seq_num,
    input  logic [31:0] ack_num,
    input  logic [3:0]  data_offset,
    input  logic [3:0]  reserved_bits,
    input  logic [7:0]  flags_byte,
    input  logic [15:0] window_size,
    input  logic [15:0] urgent_ptr,
    input  logic [15:0] data_value,
    output logic        wr_en,
    output entry_t      wr_data
);

    logic [15:0] ctl_word;
    logic [19:0] wide_sum;
    logic [16:0] fold_one;
    logic [15:0] header_word;

    // control word: offset, reserved bits, flags
    assign ctl_word = {data_offset, reserved_bits, flags_byte};

    // nine header words summed wide, then end-around carry folded twice
    assign wide_sum = {4'd0, src_port} + {4'd0, dst_port}
                    + {4'd0, seq_num[31:16]} + {4'd0, seq_num[15:0]}
                    + {4'd0, ack_num[31:16]} + {4'd0, ack_num[15:0]}
                    + {4'd0, ctl_word} + {4'd0, window_size}
                    + {4'd0, urgent_ptr};
    assign fold_one    = {1'b0, wide_sum[15:0]} + {13'd0, wide_sum[19:16]};
    assign header_word = fold_one[15:0] + {15'd0, fold_one[16]};

    // classify; the unused code is accepted and dropped here
    always_comb
    begin
        wr_en        = 1'b0;
        wr_data.op   = OP_PAYLOAD;
        wr_data.word = data_value;
        unique case (req_type)
            REQ_HEADER:
            begin
                wr_en        = push && !full;
                wr_data.op   = OP_HEADER;
                wr_data.word = header_word;
            end
            REQ_PAYLOAD:
            begin
                wr_en      = push && !full;
                wr_data.op = OP_PAYLOAD;
            end
            REQ_FINISH:
            begin
                wr_en      = push && !full;
                wr_data.op = OP_FINISH;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/tcphc_queue.sv
// ----------------------------------------------------------------------------
// tcphc_queue
// short register queue decoupling the front from the back
// ----------------------------------------------------------------------------
module tcphc_queue
    import tcphc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  entry_t        wr_data,
    input  logic          rd_en,
    output entry_t        rd_data,
    output queue_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_data      = mem_reg[rd_ptr_reg];

    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/tcphc_back.sv
// ----------------------------------------------------------------------------
// tcphc_back
// running ones' complement sum, byte pairing and result register
// ----------------------------------------------------------------------------
module tcphc_back
    import tcphc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  entry_t        head,
    input  queue_status_t q_status,
    output logic          rd_en,
    input  logic          pop,
    output logic          empty,
    output logic [15:0]   checksum_value,
    output logic          checksum_ok
);

    logic [15:0] sum_reg, sum_next;
    logic [7:0]  pend_reg, pend_next;
    logic        odd_reg, odd_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] csum_reg;
    logic        ok_reg;
    logic        out_free, load_out;
    logic [15:0] fin_sum;
    logic [16:0] check_sum;

    // 16-bit add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        end
    endfunction

    assign out_free = !out_valid_reg || pop;
    assign rd_en    = !q_status.empty && ((head.op != OP_FINISH) || out_free);
    assign load_out = rd_en && (head.op == OP_FINISH);

    // finish: pad odd byte, then compare stored value against the sum
    assign fin_sum   = odd_reg ? ones_add(sum_reg, {pend_reg, 8'h00}) : sum_reg;
    assign check_sum = {1'b0, head.word} + {1'b0, fin_sum};

    // accumulator state update
    always_comb
    begin
        sum_next  = sum_reg;
        pend_next = pend_reg;
        odd_next  = odd_reg;
        if (rd_en)
        begin
            unique case (head.op)
                OP_HEADER:
                begin
                    sum_next  = head.word;
                    pend_next = '0;
                    odd_next  = 1'b0;
                end
                OP_PAYLOAD:
                begin
                    if (odd_reg)
                    begin
                        sum_next  = ones_add(sum_reg, {pend_reg, head.word[7:0]});
                        pend_next = '0;
                        odd_next  = 1'b0;
                    end
                    else
                    begin
                        pend_next = head.word[7:0];
                        odd_next  = 1'b1;
                    end
                end
                OP_FINISH:
                begin
                    sum_next  = '0;
                    pend_next = '0;
                    odd_next  = 1'b0;
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            pend_reg      <= '0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            pend_reg      <= pend_next;
            odd_reg       <= odd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            csum_reg <= ~fin_sum;
            ok_reg   <= (check_sum == 17'h0FFFF);
        end
    end

    assign empty          = !out_valid_reg;
    assign checksum_value = csum_reg;
    assign checksum_ok    = ok_reg;

endmodule

>>> rtl/tcp_header_payload_checksum_unit.sv
// ----------------------------------------------------------------------------
// tcp_header_payload_checksum_unit
// ones' complement checksum over a tcp-style header and payload bytes
// ----------------------------------------------------------------------------
// throughput: one item per cycle, set by the add in the back part, while no finish item waits on an untaken result
// a finish item is written into the queue, then loaded into the result register;
//   empty goes low once the result register holds it
// full rises only when the queue of QUEUE_DEPTH items is full behind a stalled result
// reset: asynchronous, active low; clears the sum, the odd byte, the queue and the result valid flag
module tcp_header_payload_checksum_unit
    import tcphc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [31:0] seq_num,
    input  logic [31:0] ack_num,
    input  logic [3:0]  data_offset,
    input  logic [3:0]  reserved_bits,
    input  logic [7:0]  flags_byte,
    input  logic [15:0] window_size,
    input  logic [15:0] urgent_ptr,
    input  logic [15:0] data_value,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] checksum_value,
    output logic        checksum_ok
);

    logic          wr_en;
    entry_t        wr_data;
    logic          rd_en;
    entry_t        head;
    queue_status_t q_status;

    assign full = q_status.full;

    // front: classify and fold header
    tcphc_front u_front (
        .push          (push),
        .full          (q_status.full),
        .req_type      (req_type),
        .src_port      (src_port),
        .dst_port      (dst_port),
        .seq_num       (seq_num),
        .ack_num       (ack_num),
        .data_offset   (data_offset),
        .reserved_bits (reserved_bits),
        .flags_byte    (flags_byte),
        .window_size   (window_size),
        .urgent_ptr    (urgent_ptr),
        .data_value    (data_value),
        .wr_en         (wr_en),
        .wr_data       (wr_data)
    );

    // queue between front and back
    tcphc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_data (head),
        .status  (q_status)
    );

    // back: accumulate and report
    tcphc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_status       (q_status),
        .rd_en          (rd_en),
        .pop            (pop),
        .empty          (empty),
        .checksum_value (checksum_value),
        .checksum_ok    (checksum_ok)
    );

endmodule

>>> rtl/tcphc_checker.sv
// ----------------------------------------------------------------------------
// tcphc_checker
// port-level checks of the checksum unit, bound to the top level
// ----------------------------------------------------------------------------
`include "tcp_header_payload_checksum_unit_assert.svh"

module tcphc_checker
    import tcphc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [1:0]  req_type,
    input logic        pop,
    input logic        empty,
    input logic [15:0] checksum_value,
    input logic        checksum_ok
);

    localparam int OUT_W = $clog2(QUEUE_DEPTH + 2);

    logic [OUT_W-1:0] outstanding_reg, outstanding_next;
    logic             fin_in, res_out;

    assign fin_in  = push && !full && (req_type == REQ_FINISH);
    assign res_out = pop && !empty;

    // finish items accepted whose results are not yet taken
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (fin_in && !res_out)
        begin
            outstanding_next = outstanding_reg + 1'b1;
        end
        else if (res_out && !fin_in)
        begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // a waiting result stays until taken
    `TCPHC_ASSERT_NXT(a_result_hold, !empty && !pop, !empty)

    // and its value does not change meanwhile
    `TCPHC_ASSERT_NXT(a_data_hold, !empty && !pop, $stable(checksum_value) && $stable(checksum_ok))

    // no result without a finish item behind it
    `TCPHC_ASSERT_IMP(a_no_invented, !empty, outstanding_reg != '0)

    // with nothing outstanding and no finish accepted, no result appears
    `TCPHC_ASSERT_NXT(a_stay_empty, (outstanding_reg == '0) && !fin_in, empty)

endmodule

bind tcp_header_payload_checksum_unit tcphc_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .req_type       (req_type),
    .pop            (pop),
    .empty          (empty),
    .checksum_value (checksum_value),
    .checksum_ok    (checksum_ok)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - tcp header/payload checksum unit
// drives header, payload byte, finish and unused-code items through the push/full side,
// predicts each finish result with an internal ones' complement model and
// compares value and ok flag of every popped result in order
// ----------------------------------------------------------------------------
module tb;
    import tcphc_pkg::*;

    // the fourth selector code, ignored by the block
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam logic [15:0] ALL_ONES    = 16'hFFFF;
    localparam int          TOTAL_ITEMS = 1050;
    localparam int          QUIET_FROM  = 950;
    localparam int          PAUSE_AT    = 500;
    localparam int          CYCLE_LIMIT = 500000;

    // stored-checksum choices on finish items
    localparam int STORED_MATCH = 0;
    localparam int STORED_FLIP  = 1;
    localparam int STORED_RAND  = 2;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [3:0]  data_offset;
        logic [3:0]  reserved_bits;
        logic [7:0]  flags_byte;
        logic [15:0] window_size;
        logic [15:0] urgent_ptr;
        logic [15:0] data_value;
    } segment_req_t;

    typedef struct {
        logic [15:0] value;
        logic        ok;
    } checksum_result_t;

    // running ones' complement sum and queue of expected checksums
    class checksum_scoreboard;
        logic [15:0]      running_sum = '0;
        logic [7:0]       high_byte   = '0;
        logic             odd_waiting = 1'b0;
        checksum_result_t expected_q[$];
        int               errors      = 0;

        function logic [15:0] end_around_add(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        endfunction

        // sum with any trailing odd byte padded by a zero low byte
        function logic [15:0] folded_total();
            if (odd_waiting)
                return end_around_add(running_sum, {high_byte, 8'h00});
            return running_sum;
        endfunction

        function void note_item(segment_req_t r);
            logic [15:0]      s;
            checksum_result_t res;
            case (r.kind)
                REQ_HEADER:
                begin
                    s = end_around_add(16'd0, r.src_port);
                    s = end_around_add(s, r.dst_port);
                    s = end_around_add(s, r.seq_num[31:16]);
                    s = end_around_add(s, r.seq_num[15:0]);
                    s = end_around_add(s, r.ack_num[31:16]);
                    s = end_around_add(s, r.ack_num[15:0]);
                    s = end_around_add(s, {r.data_offset, r.reserved_bits, r.flags_byte});
                    s = end_around_add(s, r.window_size);
                    s = end_around_add(s, r.urgent_ptr);
                    running_sum = s;
                    high_byte   = '0;
                    odd_waiting = 1'b0;
                end
                REQ_PAYLOAD:
                begin
                    if (odd_waiting)
                    begin
                        running_sum = end_around_add(running_sum,
                                                     {high_byte, r.data_value[7:0]});
                        high_byte   = '0;
                        odd_waiting = 1'b0;
                    end
                    else
                    begin
                        high_byte   = r.data_value[7:0];
                        odd_waiting = 1'b1;
                    end
                end
                REQ_FINISH:
                begin
                    s         = folded_total();
                    res.value = ~s;
                    res.ok    = (({1'b0, r.data_value} + {1'b0, s}) == {1'b0, ALL_ONES});
                    expected_q.push_back(res);
                    running_sum = '0;
                    high_byte   = '0;
                    odd_waiting = 1'b0;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic [15:0] value, logic ok);
            checksum_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: value %h ok %b", value, ok);
                return;
            end
            exp_res = expected_q.pop_front();
            if (value !== exp_res.value || ok !== exp_res.ok)
            begin
                errors++;
                if (errors <= 10)
                    $display("checksum mismatch: expected value %h ok %b, got value %h ok %b",
                             exp_res.value, exp_res.ok, value, ok);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  req_type = '0;
    logic [15:0] src_port = '0;
    logic [15:0] dst_port = '0;
    logic [31:0] seq_num = '0;
    logic [31:0] ack_num = '0;
    logic [3:0]  data_offset = '0;
    logic [3:0]  reserved_bits = '0;
    logic [7:0]  flags_byte = '0;
    logic [15:0] window_size = '0;
    logic [15:0] urgent_ptr = '0;
    logic [15:0] data_value = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] checksum_value;
    logic        checksum_ok;

    logic               quiet = 1'b0;
    int                 items_sent = 0;
    int                 pop_hold = 0;
    int                 cycles = 0;
    checksum_scoreboard sb = new;

    tcp_header_payload_checksum_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .src_port       (src_port),
        .dst_port       (dst_port),
        .seq_num        (seq_num),
        .ack_num        (ack_num),
        .data_offset    (data_offset),
        .reserved_bits  (reserved_bits),
        .flags_byte     (flags_byte),
        .window_size    (window_size),
        .urgent_ptr     (urgent_ptr),
        .data_value     (data_value),
        .empty          (empty),
        .pop            (pop),
        .checksum_value (checksum_value),
        .checksum_ok    (checksum_ok)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // result side: random stall bursts, none in the last part of the run
    always @(posedge clk)
    begin
        if (quiet)
            pop <= 1'b1;
        else if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            pop <= 1'b0;
            pop_hold = $urandom_range(0, 16);
        end
        else
            pop <= 1'b1;
    end

    // result check
    always @(posedge clk)
    begin
        if (rst_n && !empty && pop)
            sb.check_result(checksum_value, checksum_ok);
    end

    function automatic segment_req_t make_req(logic [1:0] kind);
        segment_req_t r;
        r.kind          = kind;
        r.src_port      = 16'($urandom);
        r.dst_port      = 16'($urandom);
        r.seq_num       = $urandom;
        r.ack_num       = $urandom;
        r.data_offset   = 4'($urandom);
        r.reserved_bits = 4'($urandom);
        r.flags_byte    = 8'($urandom);
        r.window_size   = 16'($urandom);
        r.urgent_ptr    = 16'($urandom);
        r.data_value    = 16'($urandom);
        if (kind == REQ_PAYLOAD && $urandom_range(0, 1) == 0)
            r.data_value[15:8] = '0;
        return r;
    endfunction

    // present one item, hold it until accepted, then maybe leave a gap
    task automatic push_item(segment_req_t r);
        push          <= 1'b1;
        req_type      <= r.kind;
        src_port      <= r.src_port;
        dst_port      <= r.dst_port;
        seq_num       <= r.seq_num;
        ack_num       <= r.ack_num;
        data_offset   <= r.data_offset;
        reserved_bits <= r.reserved_bits;
        flags_byte    <= r.flags_byte;
        window_size   <= r.window_size;
        urgent_ptr    <= r.urgent_ptr;
        data_value    <= r.data_value;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_item(r);
        if (r.kind != REQ_UNUSED)
            items_sent++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic push_kind(logic [1:0] kind);
        push_item(make_req(kind));
    endtask

    // finish item with a stored checksum that matches, is one bit off, or is random
    task automatic finish_segment(int mode);
        segment_req_t r;
        r = make_req(REQ_FINISH);
        if (mode == STORED_MATCH)
            r.data_value = ~sb.folded_total();
        else if (mode == STORED_FLIP)
            r.data_value = ~sb.folded_total() ^ (16'd1 << $urandom_range(0, 15));
        push_item(r);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        segment_req_t r;
        int           pick;
        int           n;
        bit           paused;

        paused = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // finish with no data right after reset
        finish_segment(STORED_MATCH);

        // payload before any header, wide value uses its low byte only
        r = make_req(REQ_PAYLOAD);
        r.data_value = 16'h12AB;
        push_item(r);
        r.data_value = 16'h00CD;
        push_item(r);
        finish_segment(STORED_MATCH);

        // all-zero header with a random stored checksum
        r = '{default: '0};
        r.kind = REQ_HEADER;
        push_item(r);
        finish_segment(STORED_RAND);

        // all-ones header, odd trailing byte
        r = '{default: '1};
        r.kind = REQ_HEADER;
        push_item(r);
        r.kind = REQ_PAYLOAD;
        push_item(r);
        push_item(r);
        push_item(r);
        finish_segment(STORED_MATCH);

        // header clears a waiting odd byte, unused code ignored mid-segment
        push_kind(REQ_PAYLOAD);
        push_kind(REQ_HEADER);
        push_kind(REQ_UNUSED);
        push_kind(REQ_PAYLOAD);
        push_kind(REQ_PAYLOAD);
        finish_segment(STORED_FLIP);

        // unused code on an idle block, then a stray finish
        push_kind(REQ_UNUSED);
        finish_segment(STORED_RAND);

        // let everything settle once before the random part
        drain_results();

        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= QUIET_FROM)
                quiet <= 1'b1;
            if (!paused && items_sent >= PAUSE_AT)
            begin
                paused = 1'b1;
                drain_results();
            end

            pick = $urandom_range(0, 99);
            if (pick < 92)
            begin
                // segment, mostly with a header in front
                if (pick < 85)
                    push_kind(REQ_HEADER);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                : $urandom_range(0, 9);
                repeat (n)
                begin
                    if ($urandom_range(0, 19) == 0)
                        push_kind(REQ_UNUSED);
                    push_kind(REQ_PAYLOAD);
                end
                pick = $urandom_range(0, 9);
                finish_segment(pick < 5 ? STORED_MATCH :
                               pick < 7 ? STORED_FLIP : STORED_RAND);
            end
            else if (pick < 96)
            begin
                // broken sequence: header or bytes with no finish
                repeat ($urandom_range(1, 4))
                    push_kind($urandom_range(0, 1) ? REQ_HEADER : REQ_PAYLOAD);
            end
            else
            begin
                // noise
                repeat ($urandom_range(1, 3))
                    push_kind(REQ_UNUSED);
                if ($urandom_range(0, 1) == 0)
                    finish_segment(STORED_RAND);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tcphc_pkg.sv
rtl/tcphc_front.sv
rtl/tcphc_queue.sv
rtl/tcphc_back.sv
rtl/tcp_header_payload_checksum_unit.sv
rtl/tcphc_checker.sv
verif/tb.sv
